>>> sv/scf_pkg.sv
package scf_pkg;

    // window size of the mask, fixed by the register map
    localparam int TAPS        = 5;
    localparam int STORE_SLOTS = TAPS - 1;

    // field widths
    localparam int SAMPLE_W = 17;
    localparam int COEFF_W  = 16;
    localparam int SCALE_W  = 8;
    localparam int OFFSET_W = 32;
    localparam int LWIDTH_W = 11;
    localparam int VSUM_W   = 40;
    localparam int VALUE_W  = 56;
    localparam int DIVS_W   = 2 * SCALE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COL_W    = 11;
    localparam int ROW_W    = 16;

    localparam logic [LWIDTH_W-1:0] LWIDTH_RESET = LWIDTH_W'(1024);
    localparam logic [COEFF_W-1:0]  CENTER_RESET = COEFF_W'(256);

    localparam int MAX_WIDTH_DEF = 1024;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEFF_0    = 3'd0,
        REG_COEFF_1    = 3'd1,
        REG_COEFF_2    = 3'd2,
        REG_COEFF_3    = 3'd3,
        REG_COEFF_4    = 3'd4,
        REG_SCALE      = 3'd5,
        REG_OFFSET     = 3'd6,
        REG_LINE_WIDTH = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VMAC,
        ST_HMAC,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

>>> sv/separable_convolution_filter_core.sv
// Separable 5x5 FIR filter over a raster stream of an edge-padded image.
// Each column is filtered vertically with the coefficient vector, the row of
// vertical sums horizontally with the same vector; the sum is divided by
// scale*scale (truncated toward zero) and offset is added. Results appear
// only where the full window lies in the image. Previous rows sit in one
// column-addressed memory (four samples per word) that is read, shifted and
// written back once per word. One 16x40 multiplier is shared by both passes
// and a radix-2 divider produces the quotient. Each word is accepted and
// run through a vertical and a horizontal pass; a word that yields a result
// then goes through the divide and output steps. The output register lets
// the next word be accepted while a result waits. The row memory has no
// clearing pass; entries are written before any result uses them.
// Registers must be written only while the block is idle.
module separable_convolution_filter_core #(
    parameter int MAX_WIDTH = scf_pkg::MAX_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_write,
    input  logic [scf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [scf_pkg::CFG_DATA_W-1:0]      cfg_data,
    // input words
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [scf_pkg::SAMPLE_W-1:0] sample,
    input  logic                                start_of_frame,
    // output words
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [scf_pkg::VALUE_W-1:0]  value,
    output logic                                end_of_row
);
    import scf_pkg::*;

    localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW0   = $clog2(MAX_WIDTH + 1);
    localparam int WW    = (WW0 > COL_W) ? WW0 : COL_W;
    localparam int MEM_W = STORE_SLOTS * SAMPLE_W;
    localparam int DCNT_W = $clog2(VALUE_W);

    // configuration registers
    logic signed [COEFF_W-1:0]  coeff_reg [TAPS];
    logic [SCALE_W-1:0]         scale_reg;
    logic signed [OFFSET_W-1:0] offset_reg;
    logic [LWIDTH_W-1:0]        line_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                coeff_reg[i] <= (i == 2) ? CENTER_RESET : '0;
            end
            scale_reg      <= SCALE_W'(1);
            offset_reg     <= '0;
            line_width_reg <= LWIDTH_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_COEFF_0:    coeff_reg[0]   <= cfg_data[COEFF_W-1:0];
                REG_COEFF_1:    coeff_reg[1]   <= cfg_data[COEFF_W-1:0];
                REG_COEFF_2:    coeff_reg[2]   <= cfg_data[COEFF_W-1:0];
                REG_COEFF_3:    coeff_reg[3]   <= cfg_data[COEFF_W-1:0];
                REG_COEFF_4:    coeff_reg[4]   <= cfg_data[COEFF_W-1:0];
                REG_SCALE:      scale_reg      <= cfg_data[SCALE_W-1:0];
                REG_OFFSET:     offset_reg     <= cfg_data[OFFSET_W-1:0];
                REG_LINE_WIDTH: line_width_reg <= cfg_data[LWIDTH_W-1:0];
                default:        ;
            endcase
        end
    end

    // state
    state_t state_reg, state_next;
    logic [2:0]               k_reg;
    logic [DCNT_W-1:0]        dcnt_reg;
    logic [COL_W-1:0]         col_count_reg;
    logic [ROW_W-1:0]         row_count_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [AW-1:0]            col_reg;
    logic                     emit_reg;
    logic                     last_reg;
    logic [DIVS_W-1:0]        dvs_reg;
    logic signed [VALUE_W-1:0] acc_reg;
    logic signed [VSUM_W-1:0] vs_reg [TAPS];
    logic                     neg_reg;
    logic [VALUE_W-1:0]       quo_reg;
    logic [DIVS_W-1:0]        rem_reg;
    logic                     out_valid_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                     end_of_row_reg;

    // row memory: word per column, oldest row in the low slot
    logic [MEM_W-1:0] row_mem [MAX_WIDTH];
    logic [MEM_W-1:0] rdata_reg;

    logic accept;
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // column / row bookkeeping for the incoming word
    logic [COL_W-1:0] cc;
    logic [ROW_W-1:0] rc;
    logic [WW-1:0]    lw_ext, w_eff, cc_ext;
    logic             last_now, emit_now;
    logic [SCALE_W-1:0] scale_eff;

    always_comb
    begin
        cc     = start_of_frame ? '0 : col_count_reg;
        rc     = start_of_frame ? '0 : row_count_reg;
        lw_ext = WW'(line_width_reg);
        cc_ext = WW'(cc);
        if (lw_ext < WW'(TAPS))
        begin
            w_eff = WW'(TAPS);
        end
        else if (lw_ext > WW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = lw_ext;
        end
        last_now  = (cc_ext >= (w_eff - WW'(1)));
        emit_now  = (rc >= ROW_W'(TAPS - 1)) && (cc >= COL_W'(TAPS - 1));
        scale_eff = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;
    end

    // shared multiplier
    logic signed [COEFF_W-1:0] mul_a;
    logic signed [VSUM_W-1:0]  mul_b;
    logic signed [VALUE_W-1:0] prod, acc_sum;
    logic signed [SAMPLE_W-1:0] slot;

    always_comb
    begin
        mul_a = coeff_reg[k_reg];
        slot  = (k_reg < 3'(STORE_SLOTS)) ? rdata_reg[k_reg * SAMPLE_W +: SAMPLE_W] : x_reg;
        if (state_reg == ST_VMAC)
        begin
            mul_b = {{(VSUM_W - SAMPLE_W){slot[SAMPLE_W-1]}}, slot};
        end
        else
        begin
            mul_b = vs_reg[k_reg];
        end
    end

    assign prod    = mul_a * mul_b;
    assign acc_sum = acc_reg + prod;

    // divider step
    logic [DIVS_W:0]     trial;
    logic                qbit;
    logic [VALUE_W-1:0]  hmag;
    logic signed [VALUE_W-1:0] qsig, result;

    always_comb
    begin
        trial  = {rem_reg, quo_reg[VALUE_W-1]};
        qbit   = (trial >= {1'b0, dvs_reg});
        hmag   = acc_sum[VALUE_W-1] ? VALUE_W'(-acc_sum) : VALUE_W'(acc_sum);
        qsig   = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
        result = qsig + {{(VALUE_W - OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_VMAC;
                end
            end
            ST_VMAC:
            begin
                if (k_reg == 3'(TAPS - 1))
                begin
                    state_next = ST_HMAC;
                end
            end
            ST_HMAC:
            begin
                if (k_reg == 3'(TAPS - 1))
                begin
                    state_next = emit_reg ? ST_DIV : ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (dcnt_reg == DCNT_W'(VALUE_W - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            dcnt_reg      <= '0;
            col_count_reg <= '0;
            row_count_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TAPS; i++)
            begin
                vs_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                k_reg <= '0;
                if (last_now)
                begin
                    col_count_reg <= '0;
                    if (rc != '1)
                    begin
                        row_count_reg <= rc + ROW_W'(1);
                    end
                    else
                    begin
                        row_count_reg <= rc;
                    end
                end
                else
                begin
                    col_count_reg <= cc + COL_W'(1);
                    row_count_reg <= rc;
                end
            end
            else if (state_reg == ST_VMAC || state_reg == ST_HMAC)
            begin
                k_reg <= (k_reg == 3'(TAPS - 1)) ? '0 : k_reg + 3'd1;
            end
            // shift in the new vertical sum
            if (state_reg == ST_VMAC && k_reg == 3'(TAPS - 1))
            begin
                for (int i = 0; i < TAPS - 1; i++)
                begin
                    vs_reg[i] <= vs_reg[i+1];
                end
                vs_reg[TAPS-1] <= acc_sum[VSUM_W-1:0];
            end
            if (state_reg == ST_HMAC)
            begin
                dcnt_reg <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                dcnt_reg <= dcnt_reg + DCNT_W'(1);
            end
            if (state_reg == ST_OUT && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg    <= sample;
            col_reg  <= AW'(cc);
            emit_reg <= emit_now;
            last_reg <= last_now;
            dvs_reg  <= scale_eff * scale_eff;
            acc_reg  <= '0;
        end
        else if (state_reg == ST_VMAC || state_reg == ST_HMAC)
        begin
            acc_reg <= (k_reg == 3'(TAPS - 1)) ? '0 : acc_sum;
        end
        // load divider with the magnitude of the horizontal sum
        if (state_reg == ST_HMAC && k_reg == 3'(TAPS - 1))
        begin
            neg_reg <= acc_sum[VALUE_W-1];
            quo_reg <= hmag;
            rem_reg <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= qbit ? DIVS_W'(trial - {1'b0, dvs_reg}) : trial[DIVS_W-1:0];
            quo_reg <= {quo_reg[VALUE_W-2:0], qbit};
        end
        if (state_reg == ST_OUT && (!out_valid_reg || out_ready))
        begin
            value_reg      <= result;
            end_of_row_reg <= last_reg;
        end
    end

    // row memory: read on accept, shifted word written back next cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg <= row_mem[AW'(cc)];
        end
        if (state_reg == ST_VMAC && k_reg == '0)
        begin
            row_mem[col_reg] <= {x_reg, rdata_reg[MEM_W-1:SAMPLE_W]};
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = value_reg;
    assign end_of_row = end_of_row_reg;

    // checks
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_VMAC && k_reg == '0))
        else $error("accepted word did not start the vertical pass");

    a_no_emit_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HMAC && k_reg == 3'(TAPS - 1) && !emit_reg) |=>
        (state_reg == ST_IDLE && !$rose(out_valid_reg)))
        else $error("result produced for an incomplete window");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && state_next == ST_IDLE) |=> out_valid_reg)
        else $error("finished result not presented");

endmodule
